[src/set_assoc_cache_lookup_lru_lfu_assert.svh]
`ifndef SET_ASSOC_CACHE_LOOKUP_LRU_LFU_ASSERT_SVH
`define SET_ASSOC_CACHE_LOOKUP_LRU_LFU_ASSERT_SVH
// check that a condition implies a consequence in the same cycle
`define SACL_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
// check that a condition implies a consequence in the next cycle
`define SACL_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

[src/sacl_pkg.sv]
package sacl_pkg;
  localparam int unsigned AddrW = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned CycW  = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgOffset  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSet     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAddr    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWays    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPolicy  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHitTime = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPenalty = 3'd6;

  localparam logic PolicyLru = 1'b0;
  localparam logic PolicyLfu = 1'b1;

  typedef struct packed {
    logic [4:0]  offset_bits;
    logic [2:0]  set_bits;
    logic [6:0]  address_bits;
    logic [3:0]  ways_in_use;
    logic        policy;
    logic [15:0] hit_time;
    logic [15:0] miss_penalty;
  } cfg_t;
endpackage

[src/sacl_ram.sv]
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/sacl_front.sv]
module sacl_front #(
  parameter int unsigned SetW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sacl_pkg::cfg_t                  cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [sacl_pkg::AddrW-1:0]      address_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output logic [SetW-1:0]                 q_set_o,
  output logic [sacl_pkg::AddrW-1:0]      q_tag_o
);
  localparam int unsigned MaxS = SetW;
  logic [2:0] s;
  logic [6:0] m, bs;
  logic signed [8:0] t;
  logic [sacl_pkg::AddrW-1:0] sh1, shifted, tmask, smask;
  logic [SetW-1:0] set_d, tag_dummy;
  logic [1:0] cnt_q, cnt_d;
  logic wr_ptr_q, rd_ptr_q;
  logic [SetW-1:0] set_q [2];
  logic [sacl_pkg::AddrW-1:0] tag_q [2];
  logic push, pop;

  always_comb begin
    s  = (32'(cfg_i.set_bits) > MaxS) ? 3'(MaxS) : cfg_i.set_bits;
    m  = (cfg_i.address_bits == 7'd0) ? 7'd1 :
         (cfg_i.address_bits > 7'd64) ? 7'd64 : cfg_i.address_bits;
    bs = 7'(cfg_i.offset_bits) + 7'(s);
    t  = $signed({2'b0, m}) - $signed({2'b0, bs});
    sh1 = address_i >> cfg_i.offset_bits;
    smask = ~({sacl_pkg::AddrW{1'b1}} << s);
    set_d = SetW'(sh1 & smask);
    shifted = address_i >> bs;
    tmask = ~({sacl_pkg::AddrW{1'b1}} << t[6:0]);
    tag_dummy = '0;
  end

  assign push = valid_i && ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_set_o = set_q[rd_ptr_q];
  assign q_tag_o = tag_q[rd_ptr_q];
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      set_q[wr_ptr_q] <= set_d | tag_dummy;
      if (t <= 0) tag_q[wr_ptr_q] <= '0;
      else if (t >= 64) tag_q[wr_ptr_q] <= shifted;
      else tag_q[wr_ptr_q] <= shifted & tmask;
    end
  end
endmodule

[src/sacl_back.sv]
`include "set_assoc_cache_lookup_lru_lfu_assert.svh"
module sacl_back #(
  parameter int unsigned SetW = 6,
  parameter int unsigned Ways = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sacl_pkg::cfg_t              cfg_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [SetW-1:0]             q_set_i,
  input  logic [sacl_pkg::AddrW-1:0]  q_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [2:0]                  way_o,
  output logic [sacl_pkg::CntW-1:0]   hits_o,
  output logic [sacl_pkg::CntW-1:0]   misses_o,
  output logic [sacl_pkg::CycW-1:0]   cycles_o
);
  localparam int unsigned Sets = 1 << SetW;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned RankW = WayW;
  localparam int unsigned EW = $clog2(Ways + 1);
  localparam int unsigned RowW = Ways * (1 + sacl_pkg::AddrW + RankW + sacl_pkg::CntW);
  localparam int unsigned ClrW = SetW + 1;
  localparam logic [1:0] StClr = 2'd0, StIdle = 2'd1, StRead = 2'd2, StOut = 2'd3;

  typedef struct packed {
    logic                       valid;
    logic [sacl_pkg::AddrW-1:0] tag;
    logic [RankW-1:0]           rank;
    logic [sacl_pkg::CntW-1:0]  freq;
  } line_t;

  logic [1:0] st_q, st_d;
  logic [ClrW-1:0] clr_q;
  logic [SetW-1:0] set_q;
  logic [sacl_pkg::AddrW-1:0] tag_q;
  logic [RowW-1:0] rdata, wdata, rst_row;
  line_t rd_l [Ways];
  line_t wr_l [Ways];
  logic we;
  logic [SetW-1:0] waddr;
  logic [EW-1:0] e;
  logic hit;
  logic done;
  logic [WayW-1:0] way;
  logic [RankW-1:0] old_rank;
  logic recent;
  logic [sacl_pkg::CntW-1:0] least;
  logic hit_q;
  logic [2:0] way_q;
  logic [sacl_pkg::CntW-1:0] hits_q, misses_q;
  logic [sacl_pkg::CycW-1:0] cyc_q;
  logic [sacl_pkg::CycW:0] cyc_sum;

  sacl_ram #(.Width(RowW), .Depth(Sets)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(q_set_i), .rdata_o(rdata)
  );

  always_comb begin
    e = (cfg_i.ways_in_use == 4'd0) ? EW'(1) :
        (32'(cfg_i.ways_in_use) > Ways) ? EW'(Ways) : EW'(cfg_i.ways_in_use);
    for (int i = 0; i < Ways; i++) begin
      rd_l[i] = rdata[i*$bits(line_t) +: $bits(line_t)];
      rst_row[i*$bits(line_t) +: $bits(line_t)] = {1'b0, {sacl_pkg::AddrW{1'b0}},
                                                    RankW'(i), {sacl_pkg::CntW{1'b0}}};
    end
    hit = 1'b0; done = 1'b0; way = '0;
    for (int i = 0; i < Ways; i++) begin
      if (!done && i < 32'(e)) begin
        if (!rd_l[i].valid) begin
          done = 1'b1; way = WayW'(i);
        end else if (rd_l[i].tag == tag_q) begin
          done = 1'b1; hit = 1'b1; way = WayW'(i);
        end
      end
    end
    recent = 1'b1;
    least = rd_l[0].freq;
    if (!done) begin
      if (cfg_i.policy == sacl_pkg::PolicyLru) begin
        for (int j = 0; j < Ways; j++)
          if (j < 32'(e) && rd_l[j].rank == '0) way = WayW'(j);
      end else begin
        recent = 1'b0;
        for (int j = 0; j < Ways; j++)
          if (j < 32'(e) && rd_l[j].freq < least) begin
            least = rd_l[j].freq; way = WayW'(j);
          end
      end
    end
    old_rank = rd_l[way].rank;
    for (int i = 0; i < Ways; i++) begin
      wr_l[i] = rd_l[i];
      if (recent && i < 32'(e) && WayW'(i) != way && rd_l[i].rank > old_rank)
        wr_l[i].rank = rd_l[i].rank - RankW'(1);
      if (WayW'(i) == way) begin
        wr_l[i].valid = 1'b1;
        wr_l[i].tag = tag_q;
        if (recent) wr_l[i].rank = RankW'(e - EW'(1));
        if (hit) wr_l[i].freq = (rd_l[i].freq == '1) ? rd_l[i].freq
                                                   : rd_l[i].freq + 1'b1;
        else if (done || cfg_i.policy == sacl_pkg::PolicyLfu) wr_l[i].freq = '0;
      end
    end
    for (int i = 0; i < Ways; i++) wdata[i*$bits(line_t) +: $bits(line_t)] = wr_l[i];
    if (st_q == StClr) begin
      we = 1'b1; waddr = clr_q[SetW-1:0]; wdata = rst_row;
    end else begin
      we = (st_q == StRead); waddr = set_q;
    end
    cyc_sum = {1'b0, cyc_q} + (sacl_pkg::CycW+1)'(cfg_i.hit_time)
            + (hit ? '0 : (sacl_pkg::CycW+1)'(cfg_i.miss_penalty));
  end

  assign q_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClr:  if (clr_q == ClrW'(Sets - 1)) st_d = StIdle;
      StIdle: if (q_valid_i) st_d = StRead;
      StRead: st_d = StOut;
      StOut:  if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0;
      hits_q <= '0; misses_q <= '0; cyc_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StClr) clr_q <= clr_q + 1'b1;
      if (st_q == StRead) begin
        if (hit) begin
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else if (misses_q != '1) misses_q <= misses_q + 1'b1;
        cyc_q <= cyc_sum[sacl_pkg::CycW] ? '1 : cyc_sum[sacl_pkg::CycW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      set_q <= q_set_i; tag_q <= q_tag_i;
    end
    if (st_q == StRead) begin
      hit_q <= hit; way_q <= 3'(way);
    end
  end

  assign hit_o = hit_q;
  assign way_o = way_q;
  assign hits_o = hits_q;
  assign misses_o = misses_q;
  assign cycles_o = cyc_q;

  `SACL_ASSERT_NEXT(a_read_out, clk_i, rst_ni, st_q == StRead, st_q == StOut)
  `SACL_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != StIdle, !q_ready_o)
  `SACL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(hits_q) && $stable(cyc_q))
endmodule

[src/set_assoc_cache_lookup_lru_lfu.sv]
// From input to result: front queue, then set row read, then result register.
// Back end holds one item at a time and does one read-modify-write of its set row.
// Front queue holds two items so the input side keeps taking while the back end works.
// Reset: asynchronous active low; then a clearing pass over all 2**MAX_SET_BITS rows
// initialises every set row before the first item is processed.
module set_assoc_cache_lookup_lru_lfu #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned WAYS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // address[63:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], way_used[3:1], hit_count[35:4], miss_count[67:36], cycle_total[107:68], zero
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  sacl_pkg::cfg_t cfg_q;
  logic q_valid, q_ready;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [63:0] q_tag;
  logic hit;
  logic [2:0] way;
  logic [31:0] hits, misses;
  logic [39:0] cyc;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{5'd0, 3'd0, 7'd64, 4'd1, sacl_pkg::PolicyLru, 16'd1, 16'd100};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sacl_pkg::CfgOffset:  cfg_q.offset_bits  <= cfg_data_i[4:0];
        sacl_pkg::CfgSet:     cfg_q.set_bits     <= cfg_data_i[2:0];
        sacl_pkg::CfgAddr:    cfg_q.address_bits <= cfg_data_i[6:0];
        sacl_pkg::CfgWays:    cfg_q.ways_in_use  <= cfg_data_i[3:0];
        sacl_pkg::CfgPolicy:  cfg_q.policy       <= cfg_data_i[0];
        sacl_pkg::CfgHitTime: cfg_q.hit_time     <= cfg_data_i;
        sacl_pkg::CfgPenalty: cfg_q.miss_penalty <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sacl_front #(.SetW(MAX_SET_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .address_i(s_axis_tdata), .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_set_o(q_set), .q_tag_o(q_tag)
  );

  sacl_back #(.SetW(MAX_SET_BITS), .Ways(WAYS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_set_i(q_set), .q_tag_i(q_tag), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .hit_o(hit), .way_o(way), .hits_o(hits), .misses_o(misses), .cycles_o(cyc)
  );

  assign m_axis_tdata = {4'd0, cyc, misses, hits, way, hit};
endmodule
